// ===== sv/stf_pkg.sv =====
package stf_pkg;

  // Field and register widths
  localparam int DRAW_W   = 16;
  localparam int THRESH_W = 17;
  localparam int RADIUS_W = 6;
  localparam int CFG_W    = 17;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ENABLE         = 2'd0,
    REG_ADD_MODE       = 2'd1,
    REG_FIRE_THRESHOLD = 2'd2,
    REG_SEARCH_RADIUS  = 2'd3
  } stf_reg_t;

  typedef struct packed {
    logic                enable;
    logic                add_mode;
    logic [THRESH_W-1:0] fire_threshold;
    logic [RADIUS_W-1:0] search_radius;
  } stf_cfg_t;

  // One beat on the input channel
  typedef struct packed {
    logic              spike_in;
    logic [DRAW_W-1:0] random_draw;
    logic              last_sample;
  } stf_sample_t;

  // One beat on the output channel
  typedef struct packed {
    logic spike_out;
    logic last_out;
  } stf_result_t;

  // One window entry as kept in the RAM
  typedef struct packed {
    logic spike;
    logic fire;
    logic changed;
  } stf_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_SRCH,
    ST_SRCH_CHK,
    ST_EMIT_RD,
    ST_EMIT_WR
  } stf_state_t;

endpackage

// ===== sv/stf_stream_if.sv =====
interface stf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/stf_ram.sv =====
module stf_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/stf_ctrl.sv =====
module stf_ctrl
  import stf_pkg::*;
#(
  parameter int MAX_RADIUS = 32,
  parameter int AW         = $clog2(2 * MAX_RADIUS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  stf_cfg_t             cfg,
  stf_stream_if.sink           samples,
  stf_stream_if.source         results,
  output logic                 ram_we,
  output logic [AW-1:0]        ram_waddr,
  output stf_entry_t           ram_wdata,
  output logic [AW-1:0]        ram_raddr,
  input  stf_entry_t           ram_rdata
);

  localparam int WIN = 2 * MAX_RADIUS - 1;
  localparam int CW  = $clog2(4 * MAX_RADIUS);

  stf_state_t        state, state_next;
  logic [AW-1:0]     head, head_next;
  logic [CW-1:0]     fill, fill_next;
  logic [CW-1:0]     lim, lim_next;
  logic [CW-1:0]     sa, sa_next;
  logic [CW-1:0]     j, j_next;
  logic [CW-1:0]     cand, cand_next;
  logic              behind, behind_next;
  logic              flush, flush_next;
  logic              out_valid, out_valid_next;
  stf_result_t       out_data, out_data_next;

  logic [RADIUS_W:0] radius_sat;
  logic [CW-1:0]     r;
  logic [CW-1:0]     d;
  logic [CW-1:0]     two_d;
  logic [CW-1:0]     scan_end;
  logic [CW-1:0]     emit_floor;
  logic [CW-1:0]     behind_age;
  logic [CW-1:0]     cand_age;
  logic              cand_ok;
  logic              want;
  logic              fired;
  stf_sample_t       beat;

  function automatic logic [AW-1:0] addr_of(input logic [AW-1:0] hd, input logic [CW-1:0] age);
    return hd - age[AW-1:0];
  endfunction

  // Effective radius, clamped to 1..MAX_RADIUS
  always_comb begin
    if (cfg.search_radius == '0) begin
      radius_sat = (RADIUS_W+1)'(1);
    end else if ({1'b0, cfg.search_radius} > (RADIUS_W+1)'(MAX_RADIUS)) begin
      radius_sat = (RADIUS_W+1)'(MAX_RADIUS);
    end else begin
      radius_sat = {1'b0, cfg.search_radius};
    end
  end

  assign r          = radius_sat[CW-1:0];
  assign d          = r - CW'(1);
  assign two_d      = {d[CW-2:0], 1'b0};
  assign scan_end   = (lim < fill) ? lim : fill;
  assign emit_floor = flush ? '0 : two_d;
  assign want       = ~cfg.add_mode;
  assign beat       = samples.data;
  assign fired      = cfg.enable && ({1'b0, beat.random_draw} < cfg.fire_threshold);

  // Next candidate of the outward search: ahead at age sa-j, behind at sa+j
  assign behind_age = sa + j;
  assign cand_age   = behind ? behind_age : (sa - j);
  assign cand_ok    = behind ? (behind_age < fill) : (j <= sa);

  assign samples.ready = (state == ST_IDLE);
  assign results.valid = out_valid;
  assign results.data  = out_data;

  // Sequencer: next state, RAM access and bookkeeping
  always_comb begin
    state_next     = state;
    head_next      = head;
    fill_next      = fill;
    lim_next       = lim;
    sa_next        = sa;
    j_next         = j;
    cand_next      = cand;
    behind_next    = behind;
    flush_next     = flush;
    out_valid_next = out_valid && !results.ready;
    out_data_next  = out_data;
    ram_we         = 1'b0;
    ram_waddr      = addr_of(head, cand);
    ram_wdata      = '{spike: ram_rdata.spike, fire: ram_rdata.fire, changed: 1'b1};
    ram_raddr      = addr_of(head, sa);

    case (state)
      ST_IDLE: begin
        if (samples.valid) begin
          // Push the new sample as age 0
          ram_we      = 1'b1;
          ram_waddr   = head + AW'(1);
          ram_wdata   = '{spike: beat.spike_in, fire: fired, changed: 1'b0};
          head_next   = head + AW'(1);
          fill_next   = fill + CW'(1);
          lim_next    = lim + CW'(1);
          flush_next  = beat.last_sample;
          sa_next     = beat.last_sample ? '0 : d;
          state_next  = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Walk the ages that may still carry an unsearched fire mark
        if (sa < scan_end) begin
          ram_raddr  = addr_of(head, sa);
          state_next = ST_SCAN_CHK;
        end else begin
          state_next = ST_EMIT_RD;
        end
      end

      ST_SCAN_CHK: begin
        if (ram_rdata.fire) begin
          if (ram_rdata.spike == want) begin
            ram_we     = 1'b1;
            ram_waddr  = addr_of(head, sa);
            sa_next    = sa + CW'(1);
            state_next = ST_SCAN;
          end else begin
            j_next      = CW'(1);
            behind_next = 1'b0;
            state_next  = ST_SRCH;
          end
        end else begin
          sa_next    = sa + CW'(1);
          state_next = ST_SCAN;
        end
      end

      ST_SRCH: begin
        if (j >= r) begin
          sa_next    = sa + CW'(1);
          state_next = ST_SCAN;
        end else if (cand_ok) begin
          ram_raddr  = addr_of(head, cand_age);
          cand_next  = cand_age;
          state_next = ST_SRCH_CHK;
        end else begin
          behind_next = !behind;
          j_next      = behind ? j + CW'(1) : j;
        end
      end

      ST_SRCH_CHK: begin
        if (ram_rdata.spike == want) begin
          ram_we     = 1'b1;
          ram_waddr  = addr_of(head, cand);
          sa_next    = sa + CW'(1);
          state_next = ST_SCAN;
        end else begin
          behind_next = !behind;
          j_next      = behind ? j + CW'(1) : j;
          state_next  = ST_SRCH;
        end
      end

      ST_EMIT_RD: begin
        // Drain the oldest entries while the fill exceeds 2*(radius-1), or down to empty on a flush
        if (fill > emit_floor) begin
          if (!out_valid || results.ready) begin
            ram_raddr  = addr_of(head, fill - CW'(1));
            state_next = ST_EMIT_WR;
          end
        end else begin
          lim_next   = flush ? '0 : ((lim < d) ? lim : d);
          state_next = ST_IDLE;
        end
      end

      ST_EMIT_WR: begin
        out_valid_next = 1'b1;
        out_data_next  = '{spike_out: ram_rdata.spike ^ ram_rdata.changed,
                           last_out:  flush && (fill == CW'(1))};
        fill_next      = fill - CW'(1);
        state_next     = ST_EMIT_RD;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      fill      <= '0;
      lim       <= '0;
      flush     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      fill      <= fill_next;
      lim       <= lim_next;
      flush     <= flush_next;
      out_valid <= out_valid_next;
    end
  end

  // Working registers of the scan and search
  always_ff @(posedge clk) begin
    sa       <= sa_next;
    j        <= j_next;
    cand     <= cand_next;
    behind   <= behind_next;
    out_data <= out_data_next;
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(WIN))
    else $error("window fill exceeds its depth");

  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_WR) |-> !out_valid)
    else $error("result lands on an occupied output slot");

  a_flush_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && $past(state) == ST_EMIT_RD && flush) |-> (fill == '0))
    else $error("flush left entries in the window");

  a_lim_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (lim < CW'(MAX_RADIUS)))
    else $error("unsearched bound out of range between items");

  a_cand_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH_CHK) |-> (cand < fill))
    else $error("search reached past the pending entries");
`endif

endmodule

// ===== sv/spike_train_random_flip.sv =====
// Steps: an item is taken in idle; each window age scanned for a fire mark is read, then checked;
//   each search candidate is read, then checked (skipped unread when off the window); each result
//   is read, then written out, and waits while the output slot is still full.
// Throughput: one item at a time, paced by the single RAM read port.
// Reset: synchronous rst empties the window and restores the register defaults; the
//   window RAM is not cleared, stale entries sit beyond the fill count and are never used.
module spike_train_random_flip
  import stf_pkg::*;
#(
  parameter int MAX_RADIUS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  stf_reg_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  stf_stream_if.sink       samples,
  stf_stream_if.source     results
);

  localparam int AW    = $clog2(2 * MAX_RADIUS);
  localparam int DEPTH = 2 ** AW;

  stf_cfg_t      cfg;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  stf_entry_t    ram_wdata;
  stf_entry_t    ram_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable         <= 1'b0;
      cfg.add_mode       <= 1'b1;
      cfg.fire_threshold <= '0;
      cfg.search_radius  <= RADIUS_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:         cfg.enable         <= cfg_data[0];
        REG_ADD_MODE:       cfg.add_mode       <= cfg_data[0];
        REG_FIRE_THRESHOLD: cfg.fire_threshold <= cfg_data[THRESH_W-1:0];
        REG_SEARCH_RADIUS:  cfg.search_radius  <= cfg_data[RADIUS_W-1:0];
        default:            cfg                <= cfg;
      endcase
    end
  end

  // Circular window of samples, fire marks and change marks
  stf_ram #(
    .WIDTH ($bits(stf_entry_t)),
    .DEPTH (DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stf_ctrl #(
    .MAX_RADIUS (MAX_RADIUS),
    .AW         (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .samples   (samples),
    .results   (results),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule
